// ===== rtl/core/crot_pkg.sv =====
`timescale 1ns / 1ps

package crot_pkg;

	// Segment table geometry.
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Fixed code values.
	localparam logic [15:0] PRIVATE_BASE = 16'hE000;
	localparam logic [15:0] NO_CODE      = 16'hFFFF;

	// Item operations.
	typedef enum logic [1:0] {
		OP_CLEAR     = 2'd0,
		OP_ADD       = 2'd1,
		OP_TRANSLATE = 2'd2,
		OP_NONE      = 2'd3
	} op_t;

	// Configuration register indexes.
	localparam logic CFG_ONLY_UNICODE   = 1'b0;
	localparam logic CFG_LAST_RANGE_END = 1'b1;

	// One stored segment.
	typedef struct packed {
		logic [15:0] start_code;
		logic [15:0] end_code;
		logic [15:0] base_value;
	} seg_entry_t;

	// Result of one scan, handed from the scanner to the top level.
	typedef struct packed {
		logic        done;
		logic        found;
		logic [15:0] mapped;
	} scan_res_t;

endpackage

// ===== rtl/core/crot_seg_ram.sv =====
`timescale 1ns / 1ps

module crot_seg_ram (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [crot_pkg::IDX_W-1:0] wr_addr,
	input  crot_pkg::seg_entry_t     wr_data,
	input  logic                     rd_en,
	input  logic [crot_pkg::IDX_W-1:0] rd_addr,
	output crot_pkg::seg_entry_t     rd_data
);
	import crot_pkg::*;

	seg_entry_t mem [TABLE_DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Single read port with registered data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/crot_scanner.sv =====
`timescale 1ns / 1ps

module crot_scanner (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [15:0]              code_in,
	input  logic [crot_pkg::CNT_W-1:0] seg_count,
	output logic                     rd_en,
	output logic [crot_pkg::IDX_W-1:0] rd_addr,
	input  crot_pkg::seg_entry_t     rd_data,
	output crot_pkg::scan_res_t      res
);
	import crot_pkg::*;

	typedef enum logic [1:0] {
		SC_IDLE = 2'b01,
		SC_RUN  = 2'b10
	} scan_state_t;

	scan_state_t      state_q;
	logic [CNT_W-1:0] addr_q;
	logic [15:0]      code_q;
	logic             pend_s1;
	logic             last_s1;
	logic             hit;
	logic [15:0]      hit_value;
	logic             issue;

	// A read is issued each running cycle until every segment has been requested.
	assign issue   = (state_q == SC_RUN) && (addr_q < seg_count);
	assign rd_en   = issue;
	assign rd_addr = addr_q[IDX_W-1:0];

	// Containment test on the entry that came back from the memory.
	assign hit       = (rd_data.start_code <= code_q) && (code_q <= rd_data.end_code);
	assign hit_value = rd_data.base_value + (code_q - rd_data.start_code);

	// Scan sequencer: issue reads in order, stop at the first hit or the last entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SC_IDLE;
			addr_q     <= '0;
			pend_s1    <= 1'b0;
			last_s1    <= 1'b0;
			res.done   <= 1'b0;
			res.found  <= 1'b0;
			res.mapped <= NO_CODE;
			code_q     <= '0;
		end else begin
			res.done <= 1'b0;
			unique case (state_q)
				SC_IDLE: begin
					pend_s1 <= 1'b0;
					if (start) begin
						code_q <= code_in;
						addr_q <= '0;
						if (seg_count == '0) begin
							res.done   <= 1'b1;
							res.found  <= 1'b0;
							res.mapped <= NO_CODE;
						end else begin
							state_q <= SC_RUN;
						end
					end
				end
				SC_RUN: begin
					pend_s1 <= issue;
					if (issue) begin
						addr_q  <= addr_q + 1'b1;
						last_s1 <= (addr_q == seg_count - 1'b1);
					end
					if (pend_s1 && (hit || last_s1)) begin
						res.done   <= 1'b1;
						res.found  <= hit;
						res.mapped <= hit ? hit_value : NO_CODE;
						state_q    <= SC_IDLE;
						pend_s1    <= 1'b0;
					end
				end
				default: begin
					state_q <= SC_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/code_range_offset_translator_core.sv =====
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     in_valid / in_stall    operation, lead_byte, low_start, low_end, code
// output    out_valid / out_stall  mapped_code, found, table_full, max_code
// config    cfg_write              cfg_index, cfg_data
//
// One item is in work at a time. Clear, add and the unused operation finish without
// a scan, as does a translate on an empty table; other translates read the segment
// memory in order through its single read port and stop at the first segment that
// holds the code or after the last one. Reset clears the configuration registers,
// segment count and running total but not the memory. A new item is taken while a
// result waits on a stalled output, and its own result waits until the output frees.
module code_range_offset_translator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  lead_byte,
	input  logic [7:0]  low_start,
	input  logic [7:0]  low_end,
	input  logic [15:0] code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] mapped_code,
	output logic        found,
	output logic        table_full,
	output logic [15:0] max_code,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import crot_pkg::*;

	logic             only_unicode_q;
	logic [15:0]      last_range_end_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0]      total_q;
	logic [15:0]      last_top_q;
	logic             busy_q;
	logic             res_ready_q;
	logic [15:0]      res_mapped_q;
	logic             res_found_q;
	logic             res_full_q;

	logic             in_xfer;
	logic             is_full;
	logic             wr_en;
	seg_entry_t       wr_data;
	logic [15:0]      span;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	seg_entry_t       rd_data;
	scan_res_t        scan_res;
	logic             move;
	logic [15:0]      table_part;
	logic [15:0]      max_value;

	assign in_stall = busy_q;
	assign in_xfer  = in_valid && !busy_q;
	assign is_full  = (count_q == CNT_W'(TABLE_DEPTH));

	// New segment entry for an add.
	assign wr_en              = in_xfer && (op_t'(operation) == OP_ADD) && !is_full;
	assign wr_data.start_code = {lead_byte, low_start};
	assign wr_data.end_code   = {lead_byte, low_end};
	assign wr_data.base_value = PRIVATE_BASE + total_q;
	assign span               = {8'd0, low_end} - {8'd0, low_start};

	crot_seg_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	crot_scanner u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_xfer && (op_t'(operation) == OP_TRANSLATE)),
		.code_in   (code),
		.seg_count (count_q),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.res       (scan_res)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			only_unicode_q   <= 1'b0;
			last_range_end_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_ONLY_UNICODE:   only_unicode_q   <= cfg_data[0];
				CFG_LAST_RANGE_END: last_range_end_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Highest mapped code from the current table state and the configured range end.
	assign table_part = (only_unicode_q || (count_q == '0)) ? 16'd0 : last_top_q;
	assign max_value  = (table_part > last_range_end_q) ? table_part : last_range_end_q;

	assign move = res_ready_q && (!out_valid || !out_stall);

	// Table state and the pending result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			total_q      <= '0;
			last_top_q   <= '0;
			busy_q       <= 1'b0;
			res_ready_q  <= 1'b0;
			res_mapped_q <= '0;
			res_found_q  <= 1'b0;
			res_full_q   <= 1'b0;
		end else begin
			if (in_xfer) begin
				busy_q       <= 1'b1;
				res_mapped_q <= '0;
				res_found_q  <= 1'b0;
				res_full_q   <= 1'b0;
				case (op_t'(operation))
					OP_CLEAR: begin
						count_q     <= '0;
						total_q     <= '0;
						res_ready_q <= 1'b1;
					end
					OP_ADD: begin
						if (is_full) begin
							res_full_q <= 1'b1;
						end else begin
							count_q    <= count_q + 1'b1;
							total_q    <= total_q + span + 16'd1;
							last_top_q <= PRIVATE_BASE + total_q + span;
						end
						res_ready_q <= 1'b1;
					end
					OP_TRANSLATE: begin
						res_ready_q <= 1'b0;
					end
					default: begin
						res_ready_q <= 1'b1;
					end
				endcase
			end else if (scan_res.done) begin
				res_mapped_q <= scan_res.mapped;
				res_found_q  <= scan_res.found;
				res_ready_q  <= 1'b1;
			end else if (move) begin
				res_ready_q <= 1'b0;
				busy_q      <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (move) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			mapped_code <= res_mapped_q;
			found       <= res_found_q;
			table_full  <= res_full_q;
			max_code    <= max_value;
		end
	end

endmodule

// ===== rtl/core/crot_checker.sv =====
`timescale 1ns / 1ps

module crot_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] mapped_code,
	input logic        found,
	input logic        table_full
);

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mapped_code))
		else $error("stalled result changed");

	// After an input transfer the block holds off further items.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while one is in work");

	// A result only appears while an item is in work.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without an item in work");

	// A dropped add carries no translation.
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> !found && (mapped_code == 16'd0))
		else $error("full flag with a translation");

endmodule

bind code_range_offset_translator_core crot_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.mapped_code (mapped_code),
	.found       (found),
	.table_full  (table_full)
);

// ===== dv/segment_map_checker.sv =====
`timescale 1ns / 1ps

module segment_map_checker
	import crot_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  lead_byte,
	input  logic [7:0]  low_start,
	input  logic [7:0]  low_end,
	input  logic [15:0] code,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] mapped_code,
	input  logic        found,
	input  logic        table_full,
	input  logic [15:0] max_code,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          open_count,
	output int          error_count,
	output int          results_checked,
	output int          hit_count,
	output int          drop_count
);

	// Fields of one result transfer.
	typedef struct packed {
		logic [15:0] mapped_code;
		logic        found;
		logic        table_full;
		logic [15:0] max_code;
	} seg_result_t;

	// Shadow copy of the segment table and the two registers.
	logic [15:0] seg_start [TABLE_DEPTH];
	logic [15:0] seg_end   [TABLE_DEPTH];
	logic [15:0] seg_base  [TABLE_DEPTH];
	int          seg_count;
	logic [15:0] code_total;
	logic        only_unicode;
	logic [15:0] last_range_end;

	// Results predicted for accepted items, oldest first.
	seg_result_t awaited_results [$];

	// Top mapped value of the newest segment, against the configured range end.
	function automatic logic [15:0] highest_mapped();
		logic [15:0] table_part;
		table_part = 16'h0000;
		if (!only_unicode && seg_count > 0)
			table_part = seg_base[seg_count - 1] +
				(seg_end[seg_count - 1] - seg_start[seg_count - 1]);
		return (table_part > last_range_end) ? table_part : last_range_end;
	endfunction

	// Apply one item to the shadow table and work out the result it causes.
	function automatic seg_result_t apply_item(input op_t op, input logic [7:0] lead,
			input logic [7:0] lo_s, input logic [7:0] lo_e, input logic [15:0] code_in);
		seg_result_t r;
		int k;
		r = '0;
		case (op)
			OP_CLEAR: begin
				seg_count  = 0;
				code_total = 16'h0000;
			end
			OP_ADD: begin
				if (seg_count >= TABLE_DEPTH) begin
					r.table_full = 1'b1;
				end else begin
					seg_start[seg_count] = {lead, lo_s};
					seg_end[seg_count]   = {lead, lo_e};
					seg_base[seg_count]  = PRIVATE_BASE + code_total;
					// A reversed trail range still advances the total, with wrap.
					code_total = code_total + {8'h00, lo_e} - {8'h00, lo_s} + 16'd1;
					seg_count++;
				end
			end
			OP_TRANSLATE: begin
				r.mapped_code = NO_CODE;
				// The first segment that holds the code wins.
				for (k = 0; k < seg_count && !r.found; k++) begin
					if (code_in <= seg_end[k] && code_in >= seg_start[k]) begin
						r.mapped_code = seg_base[k] + (code_in - seg_start[k]);
						r.found       = 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.max_code = highest_mapped();
		return r;
	endfunction

	function automatic void compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			error_count++;
			$error("%s mismatch: expected %h, got %h", name, want, got);
		end
	endfunction

	// Watch both channels and the register port at every edge.
	always @(posedge clk or negedge arst_n) begin
		seg_result_t want;
		if (!arst_n) begin
			seg_count      = 0;
			code_total     = 16'h0000;
			only_unicode   = 1'b0;
			last_range_end = 16'h0000;
			awaited_results.delete();
			open_count <= 0;
		end else begin
			// Result transfer: compare with the oldest prediction.
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (awaited_results.size() == 0) begin
					error_count++;
					$error("Result transfer with nothing expected: mapped_code %h, max_code %h",
						mapped_code, max_code);
				end else begin
					want = awaited_results.pop_front();
					compare_field("mapped_code", want.mapped_code, mapped_code);
					compare_field("found", {15'h0, want.found}, {15'h0, found});
					compare_field("table_full", {15'h0, want.table_full}, {15'h0, table_full});
					compare_field("max_code", want.max_code, max_code);
					results_checked++;
					if (want.found)
						hit_count++;
					if (want.table_full)
						drop_count++;
				end
			end

			// Register writes only change how the maximum is formed.
			if (cfg_write === 1'b1) begin
				if (cfg_index == CFG_ONLY_UNICODE)
					only_unicode = cfg_data[0];
				else if (cfg_index == CFG_LAST_RANGE_END)
					last_range_end = cfg_data;
			end

			// Input transfer: predict its result.
			if (in_valid === 1'b1 && in_stall === 1'b0)
				awaited_results.push_back(apply_item(op_t'(operation), lead_byte,
					low_start, low_end, code));

			open_count <= awaited_results.size();
		end
	end

	initial begin
		error_count     = 0;
		results_checked = 0;
		hit_count       = 0;
		drop_count      = 0;
	end

endmodule

// ===== dv/code_range_offset_translator_core_tb.sv =====
`timescale 1ns / 1ps

module code_range_offset_translator_core_tb;
	import crot_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  operation;
	logic [7:0]  lead_byte;
	logic [7:0]  low_start;
	logic [7:0]  low_end;
	logic [15:0] code;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] mapped_code;
	logic        found;
	logic        table_full;
	logic [15:0] max_code;
	logic        cfg_write;
	logic        cfg_index;
	logic [15:0] cfg_data;

	int open_count;
	int error_count;
	int results_checked;
	int hit_count;
	int drop_count;

	// Stimulus bookkeeping: segments added since the last clear, for aiming translates.
	logic [15:0] held_lo [$];
	logic [15:0] held_hi [$];
	int          items_sent;
	int          settings_used;
	bit          tx_steady;
	bit          rx_steady;

	code_range_offset_translator_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.lead_byte   (lead_byte),
		.low_start   (low_start),
		.low_end     (low_end),
		.code        (code),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.mapped_code (mapped_code),
		.found       (found),
		.table_full  (table_full),
		.max_code    (max_code),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	segment_map_checker checker_inst (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.lead_byte       (lead_byte),
		.low_start       (low_start),
		.low_end         (low_end),
		.code            (code),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.mapped_code     (mapped_code),
		.found           (found),
		.table_full      (table_full),
		.max_code        (max_code),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.open_count      (open_count),
		.error_count     (error_count),
		.results_checked (results_checked),
		.hit_count       (hit_count),
		.drop_count      (drop_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit on the run.
	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Output side: stall bursts, mostly short, a few long, with free stretches; none while rx_steady is set.
	initial begin
		int r;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_steady) begin
				out_stall <= 1'b0;
				repeat (20) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				out_stall <= 1'b1;
				if (r < 70)
					repeat ($urandom_range(1, 3)) @(posedge clk);
				else if (r < 95)
					repeat ($urandom_range(4, 12)) @(posedge clk);
				else
					repeat ($urandom_range(30, 80)) @(posedge clk);
				out_stall <= 1'b0;
				repeat ($urandom_range(0, 12)) @(posedge clk);
			end
		end
	end

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one item and hold it until the transfer.
	task automatic send_item(input op_t op, input logic [7:0] lead, input logic [7:0] lo_s,
			input logic [7:0] lo_e, input logic [15:0] code_in);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		lead_byte <= lead;
		low_start <= lo_s;
		low_end   <= lo_e;
		code      <= code_in;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		items_sent++;
		if (op == OP_CLEAR) begin
			held_lo.delete();
			held_hi.delete();
		end else if (op == OP_ADD && held_lo.size() < TABLE_DEPTH) begin
			held_lo.push_back({lead, lo_s});
			held_hi.push_back({lead, lo_e});
		end
	endtask

	// Register writes wait until every result has been taken.
	task automatic set_register(input logic idx, input logic [15:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (open_count != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Translate target: mostly inside or just outside a held segment.
	function automatic logic [15:0] pick_code();
		int          r;
		int          idx;
		logic [15:0] lo;
		logic [15:0] hi;
		r = $urandom_range(0, 99);
		if (held_lo.size() == 0 || r >= 80)
			return 16'($urandom);
		idx = $urandom_range(0, held_lo.size() - 1);
		lo  = held_lo[idx];
		hi  = held_hi[idx];
		if (r < 12)
			return lo - 16'd1;
		if (r < 24)
			return hi + 16'd1;
		if (hi < lo)
			return lo;
		return lo + 16'($urandom_range(0, hi - lo));
	endfunction

	task automatic send_add_random(input bit ordered);
		logic [7:0] a;
		logic [7:0] b;
		a = 8'($urandom);
		b = 8'($urandom);
		if (ordered && a > b)
			send_item(OP_ADD, 8'($urandom), b, a, 16'($urandom));
		else
			send_item(OP_ADD, 8'($urandom), a, b, 16'($urandom));
	endtask

	task automatic send_translate(input logic [15:0] code_in);
		send_item(OP_TRANSLATE, 8'($urandom), 8'($urandom), 8'($urandom), code_in);
	endtask

	// One random sequence: usually build a table and query it, sometimes noise.
	task automatic run_sequence();
		int r;
		int n;
		int i;
		r = $urandom_range(0, 99);
		tx_steady = ($urandom_range(0, 3) == 0);
		rx_steady = ($urandom_range(0, 3) == 0);
		if (r < 78) begin
			if ($urandom_range(0, 4) != 0)
				send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
			r = $urandom_range(0, 99);
			if (r < 85)
				n = $urandom_range(1, 16);
			else if (r < 95)
				n = $urandom_range(17, 64);
			else
				n = $urandom_range(200, 262);
			for (i = 0; i < n; i++)
				send_add_random($urandom_range(0, 6) != 0);
			n = $urandom_range(4, 24);
			for (i = 0; i < n; i++) begin
				if ($urandom_range(0, 19) == 0)
					send_item(OP_NONE, 8'($urandom), 8'($urandom), 8'($urandom),
						16'($urandom));
				else
					send_translate(pick_code());
			end
		end else begin
			n = $urandom_range(3, 12);
			for (i = 0; i < n; i++)
				send_item(op_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
					8'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		int          phase;
		int          i;
		int          target;
		logic        uni;
		logic [15:0] range_end;

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		operation <= OP_NONE;
		lead_byte <= 8'h00;
		low_start <= 8'h00;
		low_end   <= 8'h00;
		code      <= 16'h0000;
		cfg_write <= 1'b0;
		cfg_index <= CFG_ONLY_UNICODE;
		cfg_data  <= 16'h0000;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		items_sent    = 0;
		settings_used = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, edge trail bytes, reversed and overlapping segments.
		set_register(CFG_ONLY_UNICODE, 16'h0000);
		set_register(CFG_LAST_RANGE_END, 16'h0000);
		settings_used++;
		send_item(OP_TRANSLATE, 8'h00, 8'h00, 8'h00, 16'h0000);
		send_item(OP_TRANSLATE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		send_item(OP_NONE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		send_item(OP_ADD, 8'h00, 8'h00, 8'h00, 16'h0000);
		send_item(OP_ADD, 8'hFF, 8'h00, 8'hFF, 16'h0000);
		send_item(OP_ADD, 8'h81, 8'h80, 8'h40, 16'h0000);
		send_item(OP_ADD, 8'h12, 8'hA1, 8'hFE, 16'h0000);
		send_item(OP_ADD, 8'hFF, 8'h10, 8'h20, 16'h0000);
		send_translate(16'h0000);
		send_translate(16'h0001);
		send_translate(16'hFF00);
		send_translate(16'hFFFF);
		send_translate(16'hFF15);
		send_translate(16'h8160);
		send_translate(16'h12A1);
		send_translate(16'h12FE);
		send_translate(16'h12FF);
		send_item(OP_NONE, 8'h00, 8'h00, 8'h00, 16'h0000);
		send_item(OP_CLEAR, 8'h00, 8'h00, 8'h00, 16'h0000);
		send_translate(16'hFF15);
		send_item(OP_ADD, 8'h40, 8'hFF, 8'hFF, 16'h0000);
		send_translate(16'h40FF);
		send_item(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);

		// Fill the table with full trail rows so the base wraps, then overflow it.
		send_item(OP_CLEAR, 8'h00, 8'h00, 8'h00, 16'h0000);
		for (i = 0; i < TABLE_DEPTH; i++)
			send_item(OP_ADD, 8'($urandom), 8'h00, 8'hFF, 16'($urandom));
		for (i = 0; i < 3; i++)
			send_add_random(1'b1);
		for (i = 0; i < 6; i++)
			send_translate(pick_code());
		send_item(OP_NONE, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));

		// Random phases, each under its own register setting.
		target = items_sent;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin uni = 1'b0; range_end = 16'h0000; end
				1: begin uni = 1'b1; range_end = 16'hFFFF; end
				2: begin uni = 1'b0; range_end = 16'hFFFF; end
				3: begin uni = 1'b1; range_end = 16'h0000; end
				4: begin uni = 1'b0; range_end = 16'($urandom_range(16'hE000, 16'hE3FF)); end
				default: begin uni = 1'b1; range_end = 16'($urandom); end
			endcase
			set_register(CFG_ONLY_UNICODE, {15'h0000, uni});
			set_register(CFG_LAST_RANGE_END, range_end);
			settings_used++;
			target += 220;
			while (items_sent < target)
				run_sequence();
		end

		// Drain: every prediction must be met, then watch for stray results.
		in_valid <= 1'b0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		@(posedge clk);
		while (open_count != 0) @(posedge clk);
		repeat (300) @(posedge clk);

		$display("Sent %0d items under %0d register settings; %0d results checked.",
			items_sent, settings_used, results_checked);
		$display("Translate hits: %0d; adds refused on a full table: %0d.",
			hit_count, drop_count);
		if (error_count == 0 && open_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
